>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the clk / rst_n domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Width of one sample and of the window size register.
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 7;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_W-1:0]              cfg_t;

    // One input beat.
    typedef struct packed {
        sample_t sample;
        logic    first;
        logic    last;
    } in_t;

    // One result beat.
    typedef struct packed {
        sample_t window_max;
        logic    last_out;
    } out_t;

    // Result of the shared compare unit.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

>>> hdl/swm_cmp.sv
// ----------------------------------------------------------------------------
// swm_cmp
// Shared signed compare unit: reports a < b and a == b.
// ----------------------------------------------------------------------------
module swm_cmp (
    input  swm_pkg::sample_t  a,
    input  swm_pkg::sample_t  b,
    output swm_pkg::cmp_res_t res
);
    import swm_pkg::*;

    // Both operands are signed, so the ordering is two's complement order.
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

>>> hdl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data is registered and appears in the cycle after the address is given with re high.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/sliding_window_max.sv
// ----------------------------------------------------------------------------
// sliding_window_max: running maximum of the last window_size samples.
// Each item runs IDLE, then a POP_RD / POP_CMP pair for each deque entry compared,
// then APPEND and, when a result is due, FRONT_RD and EMIT; one comparator and the
// registered-read deque memory set that sequence. out_valid is registered when
// EMIT loads a result; a previous result still waiting for out_ready holds EMIT.
// Reset clears the sequencer, deque and history pointers, fill count and sets
// window_size to 1; memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_window_max #(
    parameter int WINDOW_MAX = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  swm_pkg::cfg_t   cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  swm_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output swm_pkg::out_t   out_data
);
    import swm_pkg::*;

    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int COUNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int K_W     = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(WINDOW_MAX - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WINDOW_MAX);
    localparam logic [SUM_W-1:0]   SUM_DEPTH  = SUM_W'(WINDOW_MAX);
    localparam logic [K_W-1:0]     K_DEPTH    = K_W'(WINDOW_MAX);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_POP_RD   = 6'b000010,
        S_POP_CMP  = 6'b000100,
        S_APPEND   = 6'b001000,
        S_FRONT_RD = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cfg_t               window_size_reg, window_size_next;
    sample_t            sample_reg, sample_next;
    logic               last_reg, last_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    out_t               out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_fire;
    logic               emit_load;
    logic [K_W-1:0]     ws_ext;
    logic [K_W-1:0]     k_clamp;
    logic [SUM_W-1:0]   back_sum, app_sum, old_sum;
    logic [PTR_W-1:0]   back_addr, app_addr, old_addr;
    logic [PTR_W-1:0]   head_adj;
    logic [COUNT_W-1:0] cnt_adj;
    logic [COUNT_W-1:0] fill_inc;

    logic               dq_re;
    logic [PTR_W-1:0]   dq_raddr;
    logic [SAMPLE_BITS-1:0] dq_rdata, hist_rdata;
    sample_t            cmp_a, cmp_b;
    cmp_res_t           cmp_res;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // Clamp the window size register into 1 .. WINDOW_MAX.
    always_comb
    begin
        ws_ext = K_W'(window_size_reg);
        if (ws_ext == '0)
        begin
            k_clamp = K_W'(1);
        end
        else if (ws_ext > K_DEPTH)
        begin
            k_clamp = K_DEPTH;
        end
        else
        begin
            k_clamp = ws_ext;
        end
    end

    // Ring addresses: back of the deque, append slot, oldest window sample.
    always_comb
    begin
        back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1);
        back_addr = (back_sum >= SUM_DEPTH) ? PTR_W'(back_sum - SUM_DEPTH)
                                            : PTR_W'(back_sum);

        head_adj = (count_reg == COUNT_FULL) ? ptr_inc(head_reg) : head_reg;
        cnt_adj  = (count_reg == COUNT_FULL) ? count_reg - 1'b1 : count_reg;
        app_sum  = SUM_W'(head_adj) + SUM_W'(cnt_adj);
        app_addr = (app_sum >= SUM_DEPTH) ? PTR_W'(app_sum - SUM_DEPTH)
                                          : PTR_W'(app_sum);

        old_sum  = SUM_W'(wp_reg) + SUM_DEPTH + SUM_W'(1) - SUM_W'(k_reg);
        old_addr = (old_sum >= SUM_DEPTH) ? PTR_W'(old_sum - SUM_DEPTH)
                                          : PTR_W'(old_sum);

        fill_inc = (fill_reg == COUNT_FULL) ? fill_reg : fill_reg + 1'b1;
    end

    // Deque storage, read at the back while popping and at the front to emit.
    assign dq_re    = (state_reg == S_POP_RD) || (state_reg == S_FRONT_RD);
    assign dq_raddr = (state_reg == S_FRONT_RD) ? head_reg : back_addr;

    swm_ram #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (PTR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_deque_ram (
        .clk   (clk),
        .we    (state_reg == S_APPEND),
        .waddr (app_addr),
        .wdata (sample_reg),
        .re    (dq_re),
        .raddr (dq_raddr),
        .rdata (dq_rdata)
    );

    // History ring of recent samples.
    swm_ram #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (PTR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (state_reg == S_APPEND),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (state_reg == S_FRONT_RD),
        .raddr (old_addr),
        .rdata (hist_rdata)
    );

    // The one comparator: back entry against the new sample while popping,
    // front entry against the departing sample when emitting.
    assign cmp_a = sample_t'(dq_rdata);
    assign cmp_b = (state_reg == S_EMIT) ? sample_t'(hist_rdata) : sample_reg;

    swm_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        sample_next      = sample_reg;
        last_next        = last_reg;
        k_next           = k_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg;

        if (cfg_we)
        begin
            window_size_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    sample_next = in_data.sample;
                    last_next   = in_data.last;
                    k_next      = k_clamp[COUNT_W-1:0];
                    if (in_data.first)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        wp_next    = '0;
                        fill_next  = '0;
                        state_next = S_APPEND;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = S_POP_RD;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_CMP;
            end
            S_POP_CMP:
            begin
                if (cmp_res.lt)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = (count_reg == COUNT_W'(1)) ? S_APPEND : S_POP_RD;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                head_next  = head_adj;
                count_next = cnt_adj + 1'b1;
                fill_next  = fill_inc;
                if (fill_inc >= k_reg)
                begin
                    state_next = S_FRONT_RD;
                end
                else
                begin
                    wp_next    = ptr_inc(wp_reg);
                    state_next = S_IDLE;
                end
            end
            S_FRONT_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    out_data_next.window_max = cmp_a;
                    out_data_next.last_out   = last_reg;
                    out_valid_next           = 1'b1;
                    if (cmp_res.eq)
                    begin
                        head_next  = ptr_inc(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    wp_next    = ptr_inc(wp_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= cfg_t'(1);
            head_reg        <= '0;
            count_reg       <= '0;
            wp_reg          <= '0;
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

    // Checks on the deque bookkeeping and the result hand-off.
    `ASSERT_CLK(a_count_bound, count_reg <= COUNT_FULL, "deque count above depth")
    `ASSERT_CLK(a_fill_bound, fill_reg <= COUNT_FULL, "fill count above depth")
    `ASSERT_CLK(a_pop_nonempty, (state_reg == S_POP_RD) |-> (count_reg != '0), "pop on empty")
    `ASSERT_CLK(a_append_grows, (state_reg == S_APPEND) |=> (count_reg != '0), "empty after append")
    `ASSERT_CLK(a_emit_shows, emit_load |=> (out_valid && state_reg == S_IDLE), "result not shown")

endmodule
